>>> rtl/core/boxblur_pkg.sv
// ---------------------------------------------------------------------------
// boxblur_pkg
// Shared constants, types and the rounded mean used by the 3x3 box blur.
// ---------------------------------------------------------------------------
package boxblur_pkg;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 4096;

   // configuration port
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 13;
   localparam int CFG_WIDTH_W  = 12;
   localparam int CFG_HEIGHT_W = 13;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

   // item kinds
   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // datapath widths
   localparam int CHAN_W = 8;
   localparam int PIX_W  = 3 * CHAN_W;
   localparam int SUM_W  = 12;
   localparam int CNT_W  = 4;
   localparam int PROD_W = 26;

   // reciprocal multipliers for division by 3 and 9
   localparam int DIV3_MUL   = 2731;
   localparam int DIV3_SHIFT = 13;
   localparam int DIV9_MUL   = 1821;
   localparam int DIV9_SHIFT = 14;

   // one line buffer step as decided by the sequencer
   typedef struct packed {
      logic shift;
      logic emit;
      logic up;
      logic down;
      logic left;
      logic right;
      logic last;
   } boxblur_step_type;

   // masked neighborhood sums handed to the divider
   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
      logic [CNT_W-1:0] count;
      logic             last;
   } boxblur_sum_type;

   // rounded mean: (2*sum + count) / (2*count)
   function automatic logic [CHAN_W-1:0] blur_mean(input logic [SUM_W-1:0] sum,
                                                   input logic [CNT_W-1:0] count);
      logic [SUM_W:0]      biased;
      logic [PROD_W-1:0]   prod;
      logic [CHAN_W-1:0]   q;
      biased = '0;
      prod   = '0;
      q      = sum[CHAN_W-1:0];
      case (count)
         4'd2: begin
            biased = (SUM_W+1)'(sum) + (SUM_W+1)'(1);
            q      = biased[CHAN_W:1];
         end
         4'd3: begin
            biased = (SUM_W+1)'(sum) + (SUM_W+1)'(1);
            prod   = PROD_W'(biased) * PROD_W'(DIV3_MUL);
            q      = prod[DIV3_SHIFT +: CHAN_W];
         end
         4'd4: begin
            biased = (SUM_W+1)'(sum) + (SUM_W+1)'(2);
            q      = biased[CHAN_W+1:2];
         end
         4'd6: begin
            biased = (SUM_W+1)'(sum) + (SUM_W+1)'(3);
            prod   = PROD_W'(biased[SUM_W:1]) * PROD_W'(DIV3_MUL);
            q      = prod[DIV3_SHIFT +: CHAN_W];
         end
         4'd9: begin
            biased = (SUM_W+1)'(sum) + (SUM_W+1)'(4);
            prod   = PROD_W'(biased) * PROD_W'(DIV9_MUL);
            q      = prod[DIV9_SHIFT +: CHAN_W];
         end
         default: begin
            q = sum[CHAN_W-1:0];
         end
      endcase
      return q;
   endfunction

endpackage

>>> rtl/core/boxblur_ram.sv
// ---------------------------------------------------------------------------
// boxblur_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module boxblur_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/boxblur_seq.sv
// ---------------------------------------------------------------------------
// boxblur_seq
// Frame sequencer: configuration registers, input and output position
// counters, and the per-item decision to step the line buffer and emit.
// ---------------------------------------------------------------------------
module boxblur_seq #(
   parameter int  MAX_WIDTH  = boxblur_pkg::MAX_WIDTH_DEF,
   parameter int  MAX_HEIGHT = boxblur_pkg::MAX_HEIGHT_DEF,
   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [boxblur_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [boxblur_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_command,
   input  logic [boxblur_pkg::PIX_W-1:0]       req_pixel,
   input  logic                                adv,
   output boxblur_pkg::boxblur_step_type       step,
   output logic [CW-1:0]                       step_addr,
   output logic [boxblur_pkg::PIX_W-1:0]       step_pixel
);

   import boxblur_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int LW = $clog2(MAX_WIDTH + 2);
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   logic [CFG_WIDTH_W-1:0]  cfg_width_ff;
   logic [CFG_HEIGHT_W-1:0] cfg_height_ff;

   logic          fresh_ff,   fresh_in;
   logic          all_in_ff,  all_in_in;
   logic          extra_ff,   extra_in;
   logic [WW-1:0] frame_w_ff, frame_w_in;
   logic [HW-1:0] frame_h_ff, frame_h_in;
   logic [LW-1:0] lead_ff,    lead_in;
   logic [CW-1:0] in_col_ff,  in_col_in;
   logic [RW-1:0] in_row_ff,  in_row_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [RW-1:0] out_row_ff, out_row_in;

   logic [WW-1:0] clamp_w, w_cur, w_last;
   logic [HW-1:0] clamp_h, h_cur, h_last;
   logic          lead_full, col_end, row_end, ocol_end, orow_end;
   logic          acc, push_go, drain_go, extra_go, shift_go, emit_go, frame_done;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= WIDTH_RESET;
         cfg_height_ff <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  cfg_width_ff  <= csr_wr_data[CFG_WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: cfg_height_ff <= csr_wr_data[CFG_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // geometry clamped to the supported range
   always_comb begin
      if (cfg_width_ff == '0) begin
         clamp_w = WW'(1);
      end else if (32'(cfg_width_ff) > 32'(MAX_WIDTH)) begin
         clamp_w = WW'(MAX_WIDTH);
      end else begin
         clamp_w = WW'(cfg_width_ff);
      end
      if (cfg_height_ff == '0) begin
         clamp_h = HW'(1);
      end else if (32'(cfg_height_ff) > 32'(MAX_HEIGHT)) begin
         clamp_h = HW'(MAX_HEIGHT);
      end else begin
         clamp_h = HW'(cfg_height_ff);
      end
   end

   always_comb begin
      w_cur     = fresh_ff ? clamp_w : frame_w_ff;
      h_cur     = fresh_ff ? clamp_h : frame_h_ff;
      w_last    = w_cur - WW'(1);
      h_last    = h_cur - HW'(1);
      lead_full = (lead_ff == (LW'(w_cur) + LW'(1)));
      col_end   = (WW'(in_col_ff) == w_last);
      row_end   = (HW'(in_row_ff) == h_last);
      ocol_end  = (WW'(out_col_ff) == w_last);
      orow_end  = (HW'(out_row_ff) == h_last);

      req_tready = adv && !extra_ff;
      acc        = req_tvalid && req_tready;
      extra_go   = extra_ff && adv;
      push_go    = acc && !all_in_ff && (req_command == CMD_PUSH);
      drain_go   = acc && all_in_ff;
      shift_go   = push_go || drain_go || extra_go;
      emit_go    = ((push_go || drain_go) && lead_full) || extra_go;
      frame_done = emit_go && orow_end && ocol_end;

      step.shift = shift_go;
      step.emit  = emit_go;
      step.up    = (out_row_ff != '0);
      step.down  = !orow_end;
      step.left  = (out_col_ff != '0);
      step.right = !ocol_end;
      step.last  = orow_end && ocol_end;
      step_addr  = in_col_ff;
      step_pixel = push_go ? req_pixel : '0;
   end

   // next state of the position counters
   always_comb begin
      fresh_in   = fresh_ff;
      all_in_in  = all_in_ff;
      extra_in   = extra_ff;
      frame_w_in = frame_w_ff;
      frame_h_in = frame_h_ff;
      lead_in    = lead_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;

      if (acc && fresh_ff) begin
         frame_w_in = clamp_w;
         frame_h_in = clamp_h;
      end

      if (shift_go) begin
         fresh_in  = 1'b0;
         in_col_in = col_end ? '0 : in_col_ff + CW'(1);
         if (!lead_full) begin
            lead_in = lead_ff + LW'(1);
         end
      end

      if (push_go && col_end) begin
         if (row_end) begin
            all_in_in = 1'b1;
         end else begin
            in_row_in = in_row_ff + RW'(1);
         end
      end

      // one-row frame: first drain steps the line buffer twice
      if (drain_go && !lead_full) begin
         extra_in = 1'b1;
      end else if (extra_go) begin
         extra_in = 1'b0;
      end

      if (emit_go) begin
         if (ocol_end) begin
            out_col_in = '0;
            out_row_in = out_row_ff + RW'(1);
         end else begin
            out_col_in = out_col_ff + CW'(1);
         end
      end

      if (frame_done) begin
         fresh_in   = 1'b1;
         all_in_in  = 1'b0;
         extra_in   = 1'b0;
         lead_in    = '0;
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff   <= 1'b1;
         all_in_ff  <= 1'b0;
         extra_ff   <= 1'b0;
         frame_w_ff <= WW'(1);
         frame_h_ff <= HW'(1);
         lead_ff    <= '0;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         fresh_ff   <= fresh_in;
         all_in_ff  <= all_in_in;
         extra_ff   <= extra_in;
         frame_w_ff <= frame_w_in;
         frame_h_ff <= frame_h_in;
         lead_ff    <= lead_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

endmodule

>>> rtl/core/boxblur_window.sv
// ---------------------------------------------------------------------------
// boxblur_window
// Two-row line store in one RAM, read-modify-write with forwarding, the 3x3
// window registers and the masked neighborhood sums.
// ---------------------------------------------------------------------------
module boxblur_window #(
   parameter int  MAX_WIDTH = boxblur_pkg::MAX_WIDTH_DEF,
   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  boxblur_pkg::boxblur_step_type step,
   input  logic [CW-1:0]                 step_addr,
   input  logic [boxblur_pkg::PIX_W-1:0] step_pixel,
   output logic                          sum_valid,
   output boxblur_pkg::boxblur_sum_type  sum
);

   import boxblur_pkg::*;

   localparam int LINE_W = 2 * PIX_W;

   boxblur_step_type  s1_ff;
   logic [CW-1:0]     s1_addr_ff;
   logic [PIX_W-1:0]  s1_pix_ff;
   logic              fwd_ff, fwd_in;
   logic [LINE_W-1:0] fwd_word_ff;
   logic [LINE_W-1:0] rd_word, line_word, wr_word;

   logic [PIX_W-1:0]  win_ff [3][3];

   logic              s2_valid_ff;
   boxblur_step_type  s2_ff;
   logic              sum_valid_ff;
   boxblur_sum_type   sum_ff, sum_in;

   logic [2:0]        row_ok, col_ok;
   logic [8:0]        mask;
   logic [SUM_W-1:0]  row_red [3];
   logic [SUM_W-1:0]  row_green [3];
   logic [SUM_W-1:0]  row_blue [3];

   // upper row in the high half, middle row in the low half
   boxblur_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_ff.shift && adv),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_word),
      .rd_en   (step.shift && adv),
      .rd_addr (step_addr),
      .rd_data (rd_word)
   );

   assign line_word = fwd_ff ? fwd_word_ff : rd_word;
   assign wr_word   = {line_word[PIX_W-1:0], s1_pix_ff};
   assign fwd_in    = step.shift && s1_ff.shift && (step_addr == s1_addr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         fwd_ff       <= 1'b0;
         s2_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_ff        <= step;
         fwd_ff       <= fwd_in;
         s2_valid_ff  <= s1_ff.shift && s1_ff.emit;
         sum_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_addr_ff  <= step_addr;
         s1_pix_ff   <= step_pixel;
         fwd_word_ff <= wr_word;
         s2_ff       <= s1_ff;
         sum_ff      <= sum_in;
      end
   end

   // window shift: rows up, middle, down; columns left, center, right
   always_ff @(posedge clock) begin
      if (adv && s1_ff.shift) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= line_word[LINE_W-1:PIX_W];
         win_ff[1][2] <= line_word[PIX_W-1:0];
         win_ff[2][2] <= s1_pix_ff;
      end
   end

   // masked sums over the neighbors inside the image
   always_comb begin
      row_ok = {s2_ff.down, 1'b1, s2_ff.up};
      col_ok = {s2_ff.right, 1'b1, s2_ff.left};
      for (int r = 0; r < 3; r++) begin
         row_red[r]   = '0;
         row_green[r] = '0;
         row_blue[r]  = '0;
         for (int c = 0; c < 3; c++) begin
            mask[r*3+c] = row_ok[r] && col_ok[c];
            if (row_ok[r] && col_ok[c]) begin
               row_red[r]   = row_red[r]   + SUM_W'(win_ff[r][c][3*CHAN_W-1:2*CHAN_W]);
               row_green[r] = row_green[r] + SUM_W'(win_ff[r][c][2*CHAN_W-1:CHAN_W]);
               row_blue[r]  = row_blue[r]  + SUM_W'(win_ff[r][c][CHAN_W-1:0]);
            end
         end
      end
      sum_in.red   = row_red[0] + row_red[1] + row_red[2];
      sum_in.green = row_green[0] + row_green[1] + row_green[2];
      sum_in.blue  = row_blue[0] + row_blue[1] + row_blue[2];
      sum_in.count = CNT_W'($countones(mask));
      sum_in.last  = s2_ff.last;
   end

   assign sum_valid = sum_valid_ff;
   assign sum       = sum_ff;

endmodule

>>> rtl/core/boxblur_out.sv
// ---------------------------------------------------------------------------
// boxblur_out
// Rounded division of the neighborhood sums and the result register; its
// occupancy sets the advance enable for the whole pipeline.
// ---------------------------------------------------------------------------
module boxblur_out (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          sum_valid,
   input  boxblur_pkg::boxblur_sum_type  sum,
   output logic                          adv,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [boxblur_pkg::PIX_W-1:0] rsp_tdata,
   output logic                          rsp_tlast
);

   import boxblur_pkg::*;

   logic              rsp_tvalid_ff;
   logic [PIX_W-1:0]  rsp_tdata_ff, rsp_tdata_in;
   logic              rsp_tlast_ff;

   assign adv = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tdata_in = {blur_mean(sum.blue, sum.count),
                      blur_mean(sum.green, sum.count),
                      blur_mean(sum.red, sum.count)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= sum_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tlast_ff <= sum.last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

>>> rtl/core/box_blur_three_by_three.sv
// a result passes through the stage-1 and ram read, window, sum and output registers
// throughput: one item per cycle unless stalled, set by the single ram read-modify-write
// the first drain of a one-row frame takes two line store steps; input waits on the second
// a stalled result freezes the whole pipeline until it is taken
// reset is synchronous: counters and valids clear, geometry returns to 640 x 480,
// line store contents are not cleared and need no clearing pass
// ---------------------------------------------------------------------------
// box_blur_three_by_three
// 3x3 box blur over a raster-order RGB pixel stream with edge-aware means.
// ---------------------------------------------------------------------------
module box_blur_three_by_three #(
   parameter int MAX_WIDTH  = boxblur_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = boxblur_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [boxblur_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [boxblur_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [boxblur_pkg::PIX_W-1:0]       req_tdata,  // red, green, blue
   input  logic                                req_tuser,  // command
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [boxblur_pkg::PIX_W-1:0]       rsp_tdata,  // blurred red, green, blue
   output logic                                rsp_tlast
);

   import boxblur_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic              adv;
   boxblur_step_type  step;
   logic [CW-1:0]     step_addr;
   logic [PIX_W-1:0]  step_pixel;
   logic [PIX_W-1:0]  req_pixel;
   logic              sum_valid;
   boxblur_sum_type   sum;

   // internal pixel word is red in the high byte
   assign req_pixel = {req_tdata[CHAN_W-1:0],
                       req_tdata[2*CHAN_W-1:CHAN_W],
                       req_tdata[3*CHAN_W-1:2*CHAN_W]};

   boxblur_seq #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_tuser),
      .req_pixel   (req_pixel),
      .adv         (adv),
      .step        (step),
      .step_addr   (step_addr),
      .step_pixel  (step_pixel)
   );

   boxblur_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .step       (step),
      .step_addr  (step_addr),
      .step_pixel (step_pixel),
      .sum_valid  (sum_valid),
      .sum        (sum)
   );

   boxblur_out u_out (
      .clock      (clock),
      .reset      (reset),
      .sum_valid  (sum_valid),
      .sum        (sum),
      .adv        (adv),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> tb/sv/box_blur_three_by_three_tb.sv
// ---------------------------------------------------------------------------
// box_blur_three_by_three_tb
// Streams RGB frames of many shapes through the 3x3 box blur and checks
// every blurred pixel and its frame-end flag against an in-bench line buffer
// model with edge-aware rounded means. Covers one-pixel and one-row frames,
// clamped geometry, geometry writes in the middle of a frame, early drains,
// pixels sent after a frame is complete, and random stalls on both sides.
// ---------------------------------------------------------------------------
module box_blur_three_by_three_tb;
   import boxblur_pkg::*;

   localparam int          MAX_W       = MAX_WIDTH_DEF;
   localparam int          MAX_H       = MAX_HEIGHT_DEF;
   localparam int unsigned CYCLE_LIMIT = 1000000;

   typedef struct {
      bit [CHAN_W-1:0] red;
      bit [CHAN_W-1:0] green;
      bit [CHAN_W-1:0] blue;
      bit              last;
   } blurred_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [PIX_W-1:0]       req_tdata   = '0;  // red, green, blue
   logic                   req_tuser   = 1'b0; // command
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [PIX_W-1:0]       rsp_tdata;         // blurred red, green, blue
   logic                   rsp_tlast;

   box_blur_three_by_three DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   // blur model state
   bit [PIX_W-1:0]        upper_row [MAX_W];
   bit [PIX_W-1:0]        middle_row [MAX_W];
   bit [PIX_W-1:0]        window [3][3];
   bit [CFG_WIDTH_W-1:0]  width_reg  = WIDTH_RESET;
   bit [CFG_HEIGHT_W-1:0] height_reg = HEIGHT_RESET;
   int unsigned           pushed_count, emitted_count;
   int unsigned           push_col, emit_row, emit_col;
   int unsigned           latched_w = 1, latched_h = 1;

   blurred_type blur_expected[$];
   int unsigned frames_closed   = 0;
   int unsigned items_effective = 0;
   int unsigned results_checked = 0;
   int unsigned mismatches      = 0;
   int unsigned cycle_count     = 0;
   int unsigned send_idle_pct   = 0;
   int unsigned recv_idle_pct   = 0;
   int unsigned stall_left      = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic bit [PIX_W-1:0] random_pixel();
      bit [PIX_W-1:0] pix;
      int             ch;
      pix = PIX_W'($urandom);
      if ($urandom_range(7) == 0) begin
         for (ch = 0; ch < 3; ch++) pix[8*ch +: 8] = {8{1'($urandom_range(1))}};
      end
      return pix;
   endfunction

   task automatic line_shift(bit [PIX_W-1:0] pix);
      int unsigned col;
      int          r;
      col = (push_col >= MAX_W) ? 0 : push_col;
      for (r = 0; r < 3; r++) begin
         window[r][0] = window[r][1];
         window[r][1] = window[r][2];
      end
      window[0][2] = upper_row[col];
      window[1][2] = middle_row[col];
      window[2][2] = pix;
      upper_row[col]  = middle_row[col];
      middle_row[col] = pix;
      col++;
      push_col = (col >= latched_w) ? 0 : col;
      pushed_count++;
   endtask

   task automatic emit_mean();
      bit          row_ok [3];
      bit          col_ok [3];
      int unsigned sum [3];
      int unsigned count;
      blurred_type want;
      int          r, c, ch;
      row_ok = '{emit_row > 0, 1'b1, emit_row + 1 < latched_h};
      col_ok = '{emit_col > 0, 1'b1, emit_col + 1 < latched_w};
      sum    = '{0, 0, 0};
      count  = 0;
      for (r = 0; r < 3; r++) begin
         for (c = 0; c < 3; c++) begin
            if (row_ok[r] && col_ok[c]) begin
               for (ch = 0; ch < 3; ch++) sum[ch] += window[r][c][8*ch +: 8];
               count++;
            end
         end
      end
      want.red   = 8'((2 * sum[0] + count) / (2 * count));
      want.green = 8'((2 * sum[1] + count) / (2 * count));
      want.blue  = 8'((2 * sum[2] + count) / (2 * count));
      emitted_count++;
      want.last = emitted_count >= latched_w * latched_h;
      blur_expected.push_back(want);
      emit_col++;
      if (emit_col >= latched_w) begin
         emit_col = 0;
         emit_row++;
      end
      if (want.last) begin
         pushed_count  = 0;
         emitted_count = 0;
         push_col      = 0;
         emit_row      = 0;
         emit_col      = 0;
         frames_closed++;
      end
   endtask

   task automatic blur_predict(logic cmd, bit [PIX_W-1:0] pix);
      int unsigned total;
      if (pushed_count == 0 && emitted_count == 0) begin
         latched_w = clamp_dim(width_reg, MAX_W);
         latched_h = clamp_dim(height_reg, MAX_H);
      end
      total = latched_w * latched_h;
      if (pushed_count < total) begin
         if (cmd == CMD_DRAIN) return;
         items_effective++;
         line_shift(pix);
         if (pushed_count > latched_w + 1) emit_mean();
      end else begin
         items_effective++;
         do line_shift('0); while (pushed_count <= latched_w + 1);
         emit_mean();
      end
   endtask

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic send_item(logic cmd, bit [PIX_W-1:0] pix);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      blur_predict(cmd, pix);
   endtask

   // hold off until every expected transfer is out, then let the pipe empty
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (blur_expected.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_geometry_reg(logic [CSR_INDEX_W-1:0] idx,
                                     logic [CSR_DATA_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      if (idx == REG_IMAGE_WIDTH) width_reg = value[CFG_WIDTH_W-1:0];
      else height_reg = value[CFG_HEIGHT_W-1:0];
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(int unsigned w, int unsigned h);
      settle();
      write_geometry_reg(REG_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_geometry_reg(REG_IMAGE_HEIGHT, CSR_DATA_W'(h));
   endtask

   // everything after the last pixel acts as a drain, data or not
   task automatic finish_frame();
      int unsigned closed_before;
      closed_before = frames_closed;
      while (frames_closed == closed_before)
         send_item($urandom_range(1) ? CMD_DRAIN : CMD_PUSH, random_pixel());
   endtask

   task automatic run_frame(int unsigned noise_pct);
      int unsigned total, sent;
      total = clamp_dim(width_reg, MAX_W) * clamp_dim(height_reg, MAX_H);
      sent  = 0;
      while (sent < total) begin
         if ($urandom_range(99) < noise_pct) begin
            send_item(CMD_DRAIN, random_pixel());
         end else begin
            send_item(CMD_PUSH, random_pixel());
            sent++;
         end
         if ($urandom_range(199) == 0) settle();
      end
      finish_frame();
   endtask

   task automatic test_single_pixel_frame();
      set_geometry(0, 0);
      send_item(CMD_DRAIN, 24'h000000);
      send_item(CMD_PUSH, 24'hFFFFFF);
      send_item(CMD_PUSH, 24'h000000);
      settle();
   endtask

   task automatic test_single_row_frame();
      set_geometry(3, 1);
      send_item(CMD_PUSH, 24'hFFFFFF);
      send_item(CMD_DRAIN, 24'hFFFFFF);
      send_item(CMD_PUSH, 24'h000000);
      send_item(CMD_PUSH, 24'h01807F);
      send_item(CMD_DRAIN, 24'h123456);
      finish_frame();
   endtask

   task automatic test_geometry_latch();
      set_geometry(3, 3);
      send_item(CMD_PUSH, 24'hFFFFFF);
      send_item(CMD_PUSH, 24'h000000);
      send_item(CMD_PUSH, 24'h800080);
      send_item(CMD_PUSH, 24'h7F017F);
      settle();
      // new geometry only applies from the next frame
      write_geometry_reg(REG_IMAGE_WIDTH, CSR_DATA_W'(5));
      write_geometry_reg(REG_IMAGE_HEIGHT, CSR_DATA_W'(2));
      send_item(CMD_PUSH, 24'hFFFFFF);
      send_item(CMD_DRAIN, 24'hFFFFFF);
      send_item(CMD_PUSH, 24'h00FF00);
      send_item(CMD_PUSH, 24'hFF00FF);
      send_item(CMD_PUSH, 24'h010101);
      send_item(CMD_PUSH, 24'hFEFEFE);
      finish_frame();
   endtask

   task automatic test_long_row();
      send_idle_pct = 5;
      recv_idle_pct = 5;
      set_geometry(48, 1);
      run_frame(1);
   endtask

   task automatic test_tall_column();
      set_geometry(1, 40);
      run_frame(1);
   endtask

   task automatic test_random_frames();
      int unsigned start_items, w, h, pick;
      start_items = items_effective;
      while (items_effective - start_items < 560) begin
         if (items_effective - start_items >= 450) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 35);
            recv_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 35);
         end
         if (frames_closed != 0 && $urandom_range(3) != 0) begin
            pick = $urandom_range(9);
            if (pick == 0) begin
               w = $urandom_range(16, 64);
               h = $urandom_range(1, 3);
            end else if (pick == 1) begin
               w = $urandom_range(0, 2);
               h = $urandom_range(10, 40);
            end else begin
               w = $urandom_range(0, 12);
               h = $urandom_range(0, 8);
            end
            set_geometry(w, h);
         end
         run_frame(5);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      blurred_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (blur_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected result transfer %h last %b",
                                      rsp_tdata, rsp_tlast));
         end else begin
            want = blur_expected.pop_front();
            results_checked++;
            if (rsp_tdata[7:0] !== want.red)
               report_mismatch($sformatf("red %h, want %h", rsp_tdata[7:0], want.red));
            if (rsp_tdata[15:8] !== want.green)
               report_mismatch($sformatf("green %h, want %h", rsp_tdata[15:8], want.green));
            if (rsp_tdata[23:16] !== want.blue)
               report_mismatch($sformatf("blue %h, want %h", rsp_tdata[23:16], want.blue));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("frame end %b, want %b", rsp_tlast, want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, blur_expected.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_pixel_frame();
      test_single_row_frame();
      test_geometry_latch();
      test_long_row();
      test_tall_column();
      test_random_frames();
      settle();
      repeat (20) @(posedge clock);
      $display("ran %0d frames, %0d effective input transfers, %0d results checked",
               frames_closed, items_effective, results_checked);
      $display("shapes from 1x1 to 64 wide rows and 40 tall columns, early drains, stalls");
      if (mismatches == 0 && blur_expected.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
